/* sv/chr_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the consistent hash ring.
// No dependencies; used by chr_cell and consistent_hash_ring_top.
package chr_pkg;

  localparam int MAX_NODES = 16;
  localparam int ID_BITS   = 8;
  localparam int HASH_BITS = 32;
  localparam int CNT_W     = $clog2(MAX_NODES + 1);

  typedef logic [CNT_W-1:0] count_t;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_ERASE  = 2'd1,
    MODE_LOOKUP = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_DUP     = 3'd1,
    ST_FULL    = 3'd2,
    ST_MISSING = 3'd3,
    ST_EMPTY   = 3'd4
  } status_t;

  typedef struct packed {
    logic [HASH_BITS-1:0] hash;
    logic [ID_BITS-1:0]   id;
  } entry_t;

  typedef struct packed {
    logic [HASH_BITS-1:0] hash;
    logic [ID_BITS-1:0]   id;
    logic                 ins;
    logic                 del;
  } req_t;

  typedef struct packed {
    logic               lt;
    logic               ge;
    logic               match;
    logic [ID_BITS-1:0] pick;
  } link_t;

endpackage

/* sv/chr_cell.sv */
`timescale 1ns / 1ps
// One slot of the sorted ring: holds a hash and id, compares against the request
// and shifts toward either neighbor on insert or erase. Depends on chr_pkg.
module chr_cell (
  input  logic           clk,
  input  logic           valid,
  input  chr_pkg::req_t   req,
  input  chr_pkg::entry_t left_ent,
  input  chr_pkg::entry_t right_ent,
  input  chr_pkg::link_t  link_in,
  output chr_pkg::entry_t ent,
  output chr_pkg::link_t  link_out
);

  chr_pkg::entry_t ent_r;
  chr_pkg::entry_t ent_nxt;
  logic            lt_self;
  logic            ge_self;
  logic            eq_self;
  logic            match_chain;
  logic            sel;

  assign lt_self     = valid && (ent_r.hash < req.hash);
  assign ge_self     = valid && (ent_r.hash >= req.hash);
  assign eq_self     = valid && (ent_r.hash == req.hash);
  assign match_chain = link_in.match | eq_self;
  assign sel         = ge_self & ~link_in.ge;

  assign link_out.lt    = lt_self;
  assign link_out.ge    = link_in.ge | ge_self;
  assign link_out.match = match_chain;
  assign link_out.pick  = link_in.pick | (sel ? ent_r.id : '0);

  assign ent = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (req.ins && !lt_self) begin
      if (link_in.lt) begin
        ent_nxt.hash = req.hash;
        ent_nxt.id   = req.id;
      end else begin
        ent_nxt = left_ent;
      end
    end else if (req.del && match_chain) begin
      ent_nxt = right_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

/* sv/consistent_hash_ring_top.sv */
`timescale 1ns / 1ps
// Consistent hash ring built as a sorted row of chr_cell slots. Depends on chr_pkg.
// Each input transfer's result is registered and held until out_ready is high.
// Throughput: one item per cycle while out_ready is high; every slot compares
// in parallel; insert or erase shifts through the cell chain in the same cycle.
// Reset clears the node count and the output valid; slot contents are left as is.
module consistent_hash_ring_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_item_hash,
  input  logic [7:0]  in_node_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [7:0]  out_found_id
);

  localparam int N = chr_pkg::MAX_NODES;

  chr_pkg::entry_t ent [N];
  chr_pkg::link_t  lnk [N+1];
  chr_pkg::req_t   req;
  logic [N-1:0]    valid;

  chr_pkg::count_t count_r;
  chr_pkg::count_t count_nxt;
  logic            out_valid_r;
  logic            out_valid_nxt;
  chr_pkg::status_t out_status_r;
  chr_pkg::status_t out_status_nxt;
  logic [chr_pkg::ID_BITS-1:0] out_found_id_r;
  logic [chr_pkg::ID_BITS-1:0] out_found_id_nxt;

  logic in_fire;
  logic is_add;
  logic is_erase;
  logic is_lookup;
  logic full;
  logic empty;
  logic any_match;
  logic any_ge;
  logic ins_ok;
  logic del_ok;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign is_add    = (in_mode == chr_pkg::MODE_ADD);
  assign is_erase  = (in_mode == chr_pkg::MODE_ERASE);
  assign is_lookup = (in_mode == chr_pkg::MODE_LOOKUP);
  assign full      = (count_r == chr_pkg::count_t'(N));
  assign empty     = (count_r == '0);
  assign any_match = lnk[N].match;
  assign any_ge    = lnk[N].ge;
  assign ins_ok    = in_fire && is_add && !any_match && !full;
  assign del_ok    = in_fire && is_erase && any_match;

  assign req.hash = in_item_hash;
  assign req.id   = in_node_id;
  assign req.ins  = ins_ok;
  assign req.del  = del_ok;

  assign lnk[0].lt    = 1'b1;
  assign lnk[0].ge    = 1'b0;
  assign lnk[0].match = 1'b0;
  assign lnk[0].pick  = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    assign valid[i] = (count_r > chr_pkg::count_t'(i));
    chr_cell u_cell (
      .clk       (clk),
      .valid     (valid[i]),
      .req       (req),
      .left_ent  (ent[(i == 0) ? 0 : i - 1]),
      .right_ent (ent[(i == N - 1) ? i : i + 1]),
      .link_in   (lnk[i]),
      .ent       (ent[i]),
      .link_out  (lnk[i+1])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (ins_ok) begin
      count_nxt = count_r + 1'b1;
    end else if (del_ok) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_comb begin
    out_status_nxt   = chr_pkg::ST_OK;
    out_found_id_nxt = '0;
    if (is_add) begin
      if (any_match) begin
        out_status_nxt = chr_pkg::ST_DUP;
      end else if (full) begin
        out_status_nxt = chr_pkg::ST_FULL;
      end
    end else if (is_erase) begin
      if (!any_match) begin
        out_status_nxt = chr_pkg::ST_MISSING;
      end
    end else if (is_lookup) begin
      if (empty) begin
        out_status_nxt = chr_pkg::ST_EMPTY;
      end else begin
        out_found_id_nxt = any_ge ? lnk[N].pick : ent[0].id;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_status_r   <= out_status_nxt;
      out_found_id_r <= out_found_id_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_found_id = out_found_id_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= chr_pkg::count_t'(N))
    else $error("node count above ring capacity");

  a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ins_ok |=> (count_r == $past(count_r) + 1'b1))
    else $error("accepted add did not grow the ring");

  a_ins_del_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ins_ok && del_ok))
    else $error("insert and erase in the same cycle");

  for (genvar j = 0; j < N - 1; j++) begin : g_sorted
    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
      valid[j+1] |-> (ent[j].hash < ent[j+1].hash))
      else $error("ring slots out of hash order");
  end

endmodule
